// File: rtl/rpar_pkg.sv
// Shared types, constants and character decode for the radix text parser.
// Depends on nothing; every other file imports it.
package rpar_pkg;

  localparam int unsigned ACC_W    = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd35;

  // Digit code for a character that is not a digit or letter; it is never
  // below any 6-bit radix, so it always fails the digit range check.
  localparam logic [RADIX_W-1:0] NO_DIGIT    = 6'h3F;
  localparam logic [RADIX_W-1:0] LETTER_BASE = 6'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_DIGITS = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BASE  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // Per-string parse state.
  typedef struct packed {
    logic [ACC_W-1:0]    acc;
    logic                seen;
    logic [STATUS_W-1:0] err;
  } str_state_t;

  function automatic logic is_skip_char(input logic [CHAR_W-1:0] c);
    logic r;
    case (c) inside
      CH_SPACE, CH_APOS, CH_COMMA, CH_UNDER: r = 1'b1;
      default:                               r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [RADIX_W-1:0] char_digit(input logic [CHAR_W-1:0] c);
    logic [RADIX_W-1:0] r;
    case (c) inside
      [CH_0:CH_9]:   r = RADIX_W'(c - CH_0);
      [CH_UA:CH_UZ]: r = RADIX_W'(c - CH_UA) + LETTER_BASE;
      [CH_LA:CH_LZ]: r = RADIX_W'(c - CH_LA) + LETTER_BASE;
      default:       r = NO_DIGIT;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/rpar_mac.sv
// 128-bit multiply-add: acc * radix + digit, wrapping modulo 2^128.
// Depends on rpar_pkg.
module rpar_mac (
  input  logic [rpar_pkg::ACC_W-1:0]   acc,
  input  logic [rpar_pkg::RADIX_W-1:0] radix,
  input  logic [rpar_pkg::RADIX_W-1:0] digit,
  output logic [rpar_pkg::ACC_W-1:0]   acc_nxt
);
  import rpar_pkg::*;

  // One shifted copy of acc per radix bit; the sum is a shallow adder tree.
  logic [ACC_W-1:0] pp [RADIX_W];

  for (genvar i = 0; i < RADIX_W; i++) begin : g_pp
    assign pp[i] = radix[i] ? (acc << i) : '0;
  end

  // Balanced sum of the six partial products and the digit.
  assign acc_nxt = ((pp[0] + pp[1]) + (pp[2] + pp[3])) +
                   ((pp[4] + pp[5]) + ACC_W'(digit));

endmodule

// File: rtl/rpar_step.sv
// Decode of one character beat: skip, digit check, error latch, result build.
// Depends on rpar_pkg and rpar_mac.
module rpar_step (
  input  rpar_pkg::str_state_t          cur,
  input  logic [rpar_pkg::CHAR_W-1:0]   character,
  input  logic                          has_char,
  input  logic                          last,
  input  logic [rpar_pkg::RADIX_W-1:0]  radix,
  output rpar_pkg::str_state_t          nxt,
  output logic [rpar_pkg::ACC_W-1:0]    value,
  output logic [rpar_pkg::STATUS_W-1:0] status
);
  import rpar_pkg::*;

  logic                base_ok;
  logic [STATUS_W-1:0] err_base;
  logic [STATUS_W-1:0] err_fin;
  logic [RADIX_W-1:0]  digit;
  logic                take;
  logic                bad_digit;
  logic                do_mac;
  logic [ACC_W-1:0]    mac_out;
  str_state_t          upd;

  assign base_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign err_base  = (cur.err == STATUS_OK && !base_ok) ? STATUS_BAD_BASE : cur.err;
  assign digit     = char_digit(character);
  assign take      = has_char && (err_base == STATUS_OK) && !is_skip_char(character);
  assign bad_digit = take && (digit >= radix);
  assign do_mac    = take && !bad_digit;
  assign err_fin   = bad_digit ? STATUS_BAD_DIGIT : err_base;

  rpar_mac u_mac (
    .acc     (cur.acc),
    .radix   (radix),
    .digit   (digit),
    .acc_nxt (mac_out)
  );

  always_comb begin
    upd.acc  = do_mac ? mac_out : cur.acc;
    upd.seen = cur.seen | do_mac;
    upd.err  = err_fin;

    status = (upd.err == STATUS_OK && !upd.seen) ? STATUS_NO_DIGITS : upd.err;
    value  = (status == STATUS_OK) ? upd.acc : '0;

    // Idle beat leaves state alone; end of string clears it.
    if (!has_char && !last) begin
      nxt = cur;
    end else if (last) begin
      nxt = '0;
    end else begin
      nxt = upd;
    end
  end

endmodule

// File: rtl/radix_text_to_u128_parser.sv
// Top level of the radix text to 128-bit unsigned parser.
// Depends on rpar_pkg and rpar_step (which holds rpar_mac).
//
// Usage:
//   in_*  : one character beat per handshake (in_character, in_has_char,
//           in_last). A beat with in_has_char and in_last both low is idle
//           and changes nothing.
//   out_* : one result beat per string, on the beat that carries in_last:
//           value split in out_value_low / out_value_high and out_status
//           (0 ok, 1 invalid digit, 2 no digits, 3 bad base; value is zero
//           unless ok).
//   cfg_* : write of the 6-bit radix; always ready. Write it only while the
//           block is idle. Reset value is 10.
// Timing: a beat lands in the input register, then one pass of decode and
//   a 128 x 6 multiply-add updates the string state and, for a last beat,
//   loads the result register, which raises out_valid. Throughput is one beat
//   per cycle while no last beat waits on a held result.
// Reset (rst_n low, synchronous) empties both registers, zeroes the
//   accumulator and error state and sets radix to 10.
// Stall: a held result blocks only the next last beat; other beats keep
//   flowing, and in_ready drops once a last beat waits in the input register.
module radix_text_to_u128_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rpar_pkg::CHAR_W-1:0]    in_character,
  input  logic                           in_has_char,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rpar_pkg::HALF_W-1:0]    out_value_low,
  output logic [rpar_pkg::HALF_W-1:0]    out_value_high,
  output logic [rpar_pkg::STATUS_W-1:0]  out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpar_pkg::RADIX_W-1:0]   cfg_radix
);
  import rpar_pkg::*;

  // Input register.
  logic                in_valid_r;
  logic [CHAR_W-1:0]   char_r;
  logic                has_char_r;
  logic                last_r;

  // String state and radix.
  str_state_t          state_r;
  str_state_t          state_nxt;
  logic [RADIX_W-1:0]  radix_r;

  // Result register.
  logic                out_valid_r;
  logic [ACC_W-1:0]    value_r;
  logic [STATUS_W-1:0] status_r;
  logic [ACC_W-1:0]    value_nxt;
  logic [STATUS_W-1:0] status_nxt;

  logic                out_free;
  logic                proc_fire;
  logic                in_fire;

  assign out_free  = !out_valid_r || out_ready;
  // Advance the held beat unless it ends a string and the result slot is full.
  assign proc_fire = in_valid_r && (!last_r || out_free);
  assign in_ready  = !in_valid_r || proc_fire;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rpar_step u_step (
    .cur       (state_r),
    .character (char_r),
    .has_char  (has_char_r),
    .last      (last_r),
    .radix     (radix_r),
    .nxt       (state_nxt),
    .value     (value_nxt),
    .status    (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_r     <= in_character;
      has_char_r <= in_has_char;
      last_r     <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_r <= cfg_radix;
    end
  end

  // Load a result on a processed last beat; drop valid once it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && last_r) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_low  = value_r[HALF_W-1:0];
  assign out_value_high = value_r[ACC_W-1:HALF_W];
  assign out_status     = status_r;

  // Error results carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STATUS_OK) |-> (value_r == '0))
    else $error("error result with nonzero value");

  // A processed end of string leaves the string state cleared.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && last_r) |=> (state_r == '0))
    else $error("string state not cleared after last beat");

  // A new result appears only after a last beat was processed.
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(proc_fire && last_r))
    else $error("result without a processed last beat");

  // A radix write takes effect on the next cycle.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (radix_r == $past(cfg_radix)))
    else $error("radix write lost");

endmodule
